// ===== rtl/rrtp_pkg.sv =====
// Package for the round-robin task picker.
// Holds the item types, opcodes, task states and cell control struct.
// Used by rrtp_cell and round_robin_task_picker.
`default_nettype none

package rrtp_pkg;

	localparam int MAX_TASKS = 16;
	localparam int IDX_W     = 4;
	localparam int CNT_W     = 5;
	localparam int WAKE_W    = 32;

	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_WRITE  = 2'd1;
	localparam logic [1:0] OP_PICK   = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [1:0] TS_READY      = 2'd0;
	localparam logic [1:0] TS_SLEEP_UP   = 2'd1;
	localparam logic [1:0] TS_SLEEP_DOWN = 2'd2;
	localparam logic [1:0] TS_KILLED     = 2'd3;

	localparam logic [CNT_W-1:0] REG_TASK_COUNT = '0;
	localparam logic [CNT_W-1:0] TASK_COUNT_RST = CNT_W'(1);

	typedef struct packed {
		logic [1:0]        opcode;
		logic [IDX_W-1:0]  task_index;
		logic [1:0]        task_state_in;
		logic [WAKE_W-1:0] wake_value;
	} cmd_t;

	typedef struct packed {
		logic [IDX_W-1:0] chosen_task;
		logic             found;
	} result_t;

	typedef struct packed {
		logic wr_en;
		logic load;
		logic load_tok;
		logic search;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/round_robin_task_picker.sv =====
// Round-robin task picker: a chain of task cells, tick counter and pick sequencer.
// Tick and write items are done when accepted in idle; a pick wraps the start index
// into range, loads the token and walks it along the chain over at most the clamped
// task_count entries; the result then strobes for one cycle.
// Reset clears all entries to ready with zero wake, tick and current task to zero,
// and task_count to one. The receiver cannot stall. Depends on rrtp_pkg, rrtp_cell.
`default_nettype none

module round_robin_task_picker (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	output logic                 busy,
	input  rrtp_pkg::cmd_t       cmd,
	output logic                 result_valid,
	output rrtp_pkg::result_t    result,
	input  wire                  psel,
	input  wire                  penable,
	input  wire                  pwrite,
	input  wire [2:0]            paddr,
	input  wire [31:0]           pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_PREP   = 2'd1;
	localparam logic [1:0] S_SEARCH = 2'd2;

	logic [1:0]                         state_q;
	logic [rrtp_pkg::WAKE_W-1:0]        tick_q;
	logic [rrtp_pkg::IDX_W-1:0]         cur_q;
	logic [rrtp_pkg::CNT_W-1:0]         task_count_q;
	logic [rrtp_pkg::CNT_W-1:0]         n_q;
	logic [rrtp_pkg::CNT_W-1:0]         p_q;
	logic [rrtp_pkg::CNT_W-1:0]         k_q;
	logic                               valid_q;
	rrtp_pkg::result_t                  result_q;

	logic                               accept;
	logic                               cfg_wr;
	logic                               reg_sel;
	logic [rrtp_pkg::CNT_W-1:0]         n_eff;
	logic [rrtp_pkg::MAX_TASKS-1:0]     hit;
	logic [rrtp_pkg::MAX_TASKS-1:0]     pass;
	logic [rrtp_pkg::MAX_TASKS-1:0]     is_last;
	logic [rrtp_pkg::MAX_TASKS-1:0]     tok_in;
	logic                               any_hit;
	logic [rrtp_pkg::IDX_W-1:0]         hit_idx;
	logic                               wrap_tok;

	assign busy         = (state_q != S_IDLE);
	assign accept       = start && !busy;
	assign pready       = 1'b1;
	assign reg_sel      = (rrtp_pkg::CNT_W'(paddr[2]) == rrtp_pkg::REG_TASK_COUNT);
	assign cfg_wr       = psel && penable && pwrite && reg_sel;
	assign result_valid = valid_q;
	assign result       = result_q;

	always_comb begin
		prdata = '0;
		if (reg_sel) begin
			prdata = {{(32 - rrtp_pkg::CNT_W){1'b0}}, task_count_q};
		end
	end

	always_comb begin
		priority if (task_count_q == '0) begin
			n_eff = rrtp_pkg::CNT_W'(1);
		end else if (task_count_q > rrtp_pkg::CNT_W'(rrtp_pkg::MAX_TASKS)) begin
			n_eff = rrtp_pkg::CNT_W'(rrtp_pkg::MAX_TASKS);
		end else begin
			n_eff = task_count_q;
		end
	end

	always_comb begin
		wrap_tok = 1'b0;
		any_hit  = 1'b0;
		hit_idx  = '0;
		for (int i = 0; i < rrtp_pkg::MAX_TASKS; i++) begin
			wrap_tok = wrap_tok | (pass[i] & is_last[i]);
			any_hit  = any_hit | hit[i];
			if (hit[i]) begin
				hit_idx = hit_idx | rrtp_pkg::IDX_W'(i);
			end
		end
	end

	genvar g;
	generate
		for (g = 0; g < rrtp_pkg::MAX_TASKS; g++) begin : g_cell
			rrtp_pkg::cell_ctl_t ctl;

			assign is_last[g] = (rrtp_pkg::CNT_W'(g) == n_q - rrtp_pkg::CNT_W'(1));
			if (g == 0) begin : g_first
				assign tok_in[g] = wrap_tok;
			end else begin : g_next
				assign tok_in[g] = pass[g-1] & ~is_last[g-1];
			end

			assign ctl.wr_en    = accept && (cmd.opcode == rrtp_pkg::OP_WRITE) &&
			                      (cmd.task_index == rrtp_pkg::IDX_W'(g));
			assign ctl.load     = (state_q == S_PREP) && (p_q < n_q);
			assign ctl.load_tok = (p_q == rrtp_pkg::CNT_W'(g));
			assign ctl.search   = (state_q == S_SEARCH);

			rrtp_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (ctl),
				.tick     (tick_q),
				.wr_state (cmd.task_state_in),
				.wr_wake  (cmd.wake_value),
				.tok_in   (tok_in[g]),
				.hit      (hit[g]),
				.pass     (pass[g])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			tick_q       <= '0;
			cur_q        <= '0;
			task_count_q <= rrtp_pkg::TASK_COUNT_RST;
			n_q          <= rrtp_pkg::CNT_W'(1);
			p_q          <= '0;
			k_q          <= '0;
			valid_q      <= 1'b0;
			result_q     <= '0;
		end else begin
			valid_q <= 1'b0;
			if (cfg_wr) begin
				task_count_q <= pwdata[rrtp_pkg::CNT_W-1:0];
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (cmd.opcode == rrtp_pkg::OP_TICK) begin
							tick_q <= tick_q + rrtp_pkg::WAKE_W'(1);
						end else if (cmd.opcode == rrtp_pkg::OP_PICK) begin
							n_q     <= n_eff;
							p_q     <= {1'b0, cur_q} + rrtp_pkg::CNT_W'(1);
							k_q     <= '0;
							state_q <= S_PREP;
						end
					end
				end
				S_PREP: begin
					if (p_q >= n_q) begin
						p_q <= p_q - n_q;
					end else begin
						state_q <= S_SEARCH;
					end
				end
				S_SEARCH: begin
					if (any_hit) begin
						cur_q                <= hit_idx;
						result_q.chosen_task <= hit_idx;
						result_q.found       <= 1'b1;
						valid_q              <= 1'b1;
						state_q              <= S_IDLE;
					end else if (k_q == n_q - rrtp_pkg::CNT_W'(1)) begin
						result_q.chosen_task <= cur_q;
						result_q.found       <= 1'b0;
						valid_q              <= 1'b1;
						state_q              <= S_IDLE;
					end else begin
						k_q <= k_q + rrtp_pkg::CNT_W'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rrtp_cell.sv =====
// One task entry of the picker chain: status, wake value and search token.
// The token moves to the neighbor cell each search cycle until a runnable entry holds it.
// Depends on rrtp_pkg.
`default_nettype none

module rrtp_cell (
	input  wire                          clk,
	input  wire                          arst_n,
	input  rrtp_pkg::cell_ctl_t          ctl,
	input  wire [rrtp_pkg::WAKE_W-1:0]   tick,
	input  wire [1:0]                    wr_state,
	input  wire [rrtp_pkg::WAKE_W-1:0]   wr_wake,
	input  wire                          tok_in,
	output logic                         hit,
	output logic                         pass
);

	logic [1:0]                  state_q;
	logic [rrtp_pkg::WAKE_W-1:0] wake_q;
	logic                        tok_q;
	logic                        runnable;

	always_comb begin
		runnable = 1'b1;
		unique case (state_q)
			rrtp_pkg::TS_READY:      runnable = 1'b1;
			rrtp_pkg::TS_SLEEP_UP:   runnable = !(wake_q < tick);
			rrtp_pkg::TS_SLEEP_DOWN: runnable = !(wake_q > tick);
			rrtp_pkg::TS_KILLED:     runnable = 1'b0;
			default:                 runnable = 1'b0;
		endcase
	end

	assign hit  = tok_q & runnable;
	assign pass = tok_q & ~runnable;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrtp_pkg::TS_READY;
			wake_q  <= '0;
			tok_q   <= 1'b0;
		end else begin
			if (ctl.wr_en) begin
				state_q <= wr_state;
				wake_q  <= wr_wake;
			end else if (ctl.search && hit) begin
				wake_q <= '0;
			end
			if (ctl.load) begin
				tok_q <= ctl.load_tok;
			end else if (ctl.search) begin
				tok_q <= tok_in;
			end
		end
	end

endmodule

`default_nettype wire
